FILE: rtl/core/wac_pkg.sv
// Package for the wrench average and calibrate unit.
// Holds sizes, the reset ratio and the calibration matrix. No dependencies.
package wac_pkg;
  localparam int unsigned Chans = 6;
  localparam int unsigned CfgBits = 7;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoefBits = 18;
  localparam logic [CfgBits-1:0] ResetRatio = 7'd10;

  function automatic logic signed [CoefBits-1:0] cal_coef(input logic [2:0] r,
                                                          input logic [2:0] c);
    logic signed [CoefBits-1:0] k;
    k = '0;
    unique case ({r, c})
      6'o00: k = 18'sd66598;  6'o01: k = 18'sd1343;   6'o02: k = 18'sd79;
      6'o03: k = -18'sd184;   6'o04: k = -18'sd10741; 6'o05: k = -18'sd492;
      6'o10: k = -18'sd1239;  6'o11: k = 18'sd66519;  6'o12: k = 18'sd170;
      6'o13: k = 18'sd9667;   6'o14: k = -18'sd983;   6'o15: k = 18'sd485;
      6'o20: k = -18'sd721;   6'o21: k = -18'sd557;   6'o22: k = 18'sd65536;
      6'o23: k = 18'sd1724;   6'o24: k = -18'sd20;    6'o25: k = -18'sd2536;
      6'o30: k = -18'sd33;    6'o31: k = 18'sd33;     6'o32: k = -18'sd52;
      6'o33: k = 18'sd66598;  6'o34: k = 18'sd1153;   6'o35: k = -18'sd46;
      6'o40: k = -18'sd46;    6'o41: k = -18'sd26;    6'o42: k = 18'sd7;
      6'o43: k = -18'sd1029;  6'o44: k = 18'sd66198;  6'o45: k = 18'sd79;
      6'o50: k = 18'sd7;      6'o51: k = -18'sd79;    6'o52: k = -18'sd33;
      6'o53: k = 18'sd282;    6'o54: k = -18'sd269;   6'o55: k = 18'sd65824;
      default: k = '0;
    endcase
    return k;
  endfunction
endpackage

FILE: rtl/core/wac_if.sv
// Valid/ready channel interfaces for the wrench unit.
// Depends on nothing; input payload widths follow the SampleBits parameter, output payloads are 32 bits.
interface wac_in_if #(parameter int unsigned SampleBits = 32) ();
  logic valid;
  logic ready;
  logic signed [SampleBits-1:0] force_x, force_y, force_z;
  logic signed [SampleBits-1:0] torque_x, torque_y, torque_z;
  modport source (output valid, force_x, force_y, force_z, torque_x, torque_y,
                  torque_z, input ready);
  modport sink (input valid, force_x, force_y, force_z, torque_x, torque_y,
                torque_z, output ready);
endinterface

interface wac_out_if ();
  logic valid;
  logic ready;
  logic signed [31:0] avg_force_x, avg_force_y, avg_force_z;
  logic signed [31:0] avg_torque_x, avg_torque_y, avg_torque_z;
  logic signed [31:0] cal_force_x, cal_force_y, cal_force_z;
  logic signed [31:0] cal_torque_x, cal_torque_y, cal_torque_z;
  modport source (output valid, avg_force_x, avg_force_y, avg_force_z, avg_torque_x,
                  avg_torque_y, avg_torque_z, cal_force_x, cal_force_y, cal_force_z,
                  cal_torque_x, cal_torque_y, cal_torque_z, input ready);
  modport sink (input valid, avg_force_x, avg_force_y, avg_force_z, avg_torque_x,
                avg_torque_y, avg_torque_z, cal_force_x, cal_force_y, cal_force_z,
                cal_torque_x, cal_torque_y, cal_torque_z, output ready);
endinterface

FILE: rtl/core/wrench_average_and_calibrate_unit.sv
// Top level of the wrench average and calibrate unit.
// Depends on wac_pkg, wac_if, wac_front, wac_queue and wac_back.
//
//   channel    direction  contents
//   in_ch      sink       six Q16.16 force/torque samples per item
//   out_ch     source     six averages and six calibrated values per item
//   cfg        write      decimation ratio, 7 bits, reset 10
//
// The front takes one item per cycle while the queue has room; most items
// only add into the sums. A ratio-completing item takes the back through
// a start from idle, a serial restoring divide of each channel, 36
// multiply-adds on one multiplier and the offer of the result until taken.
// Reset clears the sums, the count, the queue and the ratio back to 10.
// A stalled output holds the back; two more finished sums may wait in the queue.
module wrench_average_and_calibrate_unit import wac_pkg::*; #(
  parameter int unsigned MaxRatio = 64,
  parameter int unsigned SampleBits = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  wac_in_if.sink in_ch,
  wac_out_if.source out_ch,
  input  logic cfg_we_i,
  input  logic [CfgBits-1:0] cfg_wdata_i
);
  localparam int unsigned RatioBits = $clog2(MaxRatio + 1);
  localparam int unsigned SumBits = SampleBits + RatioBits - 1;

  logic [CfgBits-1:0] ratio_q;
  logic [RatioBits-1:0] eff_ratio;
  logic signed [Chans-1:0][SampleBits-1:0] sample;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  logic signed [Chans-1:0][SumBits-1:0] fq_sums, qb_sums;
  logic signed [Chans-1:0][31:0] avg, cal;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ratio_q <= ResetRatio;
    else if (cfg_we_i) ratio_q <= cfg_wdata_i;
  end

  // A ratio of zero counts as one; anything above the maximum is clipped.
  always_comb begin
    priority if (ratio_q == '0) eff_ratio = RatioBits'(1);
    else if (32'(ratio_q) > MaxRatio) eff_ratio = RatioBits'(MaxRatio);
    else eff_ratio = RatioBits'(ratio_q);
  end

  assign sample = {in_ch.torque_z, in_ch.torque_y, in_ch.torque_x,
                   in_ch.force_z, in_ch.force_y, in_ch.force_x};

  wac_front #(.SampleBits(SampleBits), .SumBits(SumBits), .RatioBits(RatioBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .sample_i(sample), .ratio_i(eff_ratio), .job_valid_o(fq_valid),
    .job_ready_i(fq_ready), .job_sums_o(fq_sums));

  wac_queue #(.Width(Chans * SumBits), .Depth(2)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_data_i(fq_sums),
    .rd_valid_o(qb_valid), .rd_ready_i(qb_ready), .rd_data_o(qb_sums));

  wac_back #(.SumBits(SumBits), .RatioBits(RatioBits)) u_back (
    .clk_i, .rst_ni, .job_valid_i(qb_valid), .job_ready_o(qb_ready),
    .job_sums_i(qb_sums), .ratio_i(eff_ratio), .res_valid_o(out_ch.valid),
    .res_ready_i(out_ch.ready), .avg_o(avg), .cal_o(cal));

  assign out_ch.avg_force_x = avg[0];
  assign out_ch.avg_force_y = avg[1];
  assign out_ch.avg_force_z = avg[2];
  assign out_ch.avg_torque_x = avg[3];
  assign out_ch.avg_torque_y = avg[4];
  assign out_ch.avg_torque_z = avg[5];
  assign out_ch.cal_force_x = cal[0];
  assign out_ch.cal_force_y = cal[1];
  assign out_ch.cal_force_z = cal[2];
  assign out_ch.cal_torque_x = cal[3];
  assign out_ch.cal_torque_y = cal[4];
  assign out_ch.cal_torque_z = cal[5];

  // The effective ratio always lies in one to the maximum.
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eff_ratio != '0 && 32'(eff_ratio) <= MaxRatio) else $error("ratio out of range");
  // Input is blocked exactly when the queue is full.
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fq_ready |-> !in_ch.ready) else $error("input taken with full queue");
  // A result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(cal))
    else $error("result dropped");
endmodule

FILE: rtl/core/wac_front.sv
// Front part: accumulates samples and hands finished sums to the queue.
// Depends on wac_pkg.
module wac_front import wac_pkg::*; #(
  parameter int unsigned SampleBits = 32,
  parameter int unsigned SumBits = 38,
  parameter int unsigned RatioBits = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [Chans-1:0][SampleBits-1:0] sample_i,
  input  logic [RatioBits-1:0] ratio_i,
  output logic job_valid_o,
  input  logic job_ready_i,
  output logic signed [Chans-1:0][SumBits-1:0] job_sums_o
);
  logic signed [Chans-1:0][SumBits-1:0] sums_q, sums_d;
  logic [RatioBits-1:0] count_q;
  logic [RatioBits:0] cnt_next;
  logic take, done;

  // An item is only taken when the queue can absorb a possible result.
  assign in_ready_o = job_ready_i;
  assign take = in_valid_i && in_ready_o;
  assign cnt_next = {1'b0, count_q} + 1'b1;
  assign done = cnt_next >= {1'b0, ratio_i};

  always_comb begin
    for (int i = 0; i < Chans; i++) begin
      sums_d[i] = sums_q[i] + SumBits'($signed(sample_i[i]));
    end
  end

  assign job_valid_o = take && done;
  assign job_sums_o = sums_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
      count_q <= '0;
    end else if (take) begin
      if (done) begin
        sums_q <= '0;
        count_q <= '0;
      end else begin
        sums_q <= sums_d;
        count_q <= cnt_next[RatioBits-1:0];
      end
    end
  end
endmodule

FILE: rtl/core/wac_queue.sv
// Two-entry queue of finished sums between the front and back parts.
// Depends on wac_pkg.
module wac_queue import wac_pkg::*; #(
  parameter int unsigned Width = 228,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output logic [Width-1:0] rd_data_o
);
  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  logic [Width-1:0] mem_q [Depth];
  logic [PtrBits-1:0] wp_q, rp_q;
  logic [PtrBits:0] fill_q;
  logic wr, rd;

  assign wr_ready_o = fill_q != (PtrBits+1)'(Depth);
  assign rd_valid_o = fill_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      fill_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PtrBits'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == PtrBits'(Depth-1)) ? '0 : rp_q + 1'b1;
      fill_q <= fill_q + (PtrBits+1)'(wr) - (PtrBits+1)'(rd);
    end
  end
endmodule

FILE: rtl/core/wac_back.sv
// Back part: restoring divide of each sum, then 36 serial multiply-adds.
// Depends on wac_pkg.
module wac_back import wac_pkg::*; #(
  parameter int unsigned SumBits = 38,
  parameter int unsigned RatioBits = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  logic signed [Chans-1:0][SumBits-1:0] job_sums_i,
  input  logic [RatioBits-1:0] ratio_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output logic signed [Chans-1:0][31:0] avg_o,
  output logic signed [Chans-1:0][31:0] cal_o
);
  typedef enum logic [3:0] {
    StIdle = 4'b0001, StDiv = 4'b0010, StMac = 4'b0100, StOut = 4'b1000
  } state_e;
  localparam int unsigned CntBits = $clog2(SumBits + 1);
  localparam int unsigned AccBits = 56;

  state_e state_q;
  logic [2:0] ch_q, col_q;
  logic [CntBits-1:0] bit_q;
  logic [SumBits-1:0] quo_q, mag;
  logic [RatioBits:0] rem_q, trial;
  logic neg_q;
  logic signed [AccBits-1:0] acc_q, prod;
  logic signed [Chans-1:0][31:0] avg_q, cal_q;
  logic signed [SumBits:0] sq;
  logic signed [AccBits-1:0] shifted;
  logic signed [31:0] sat_avg;

  // The job is released from the queue once its last channel is divided.
  assign job_ready_o = state_q == StDiv && bit_q == CntBits'(SumBits) &&
                       ch_q == 3'(Chans-1);
  assign res_valid_o = state_q == StOut;
  assign avg_o = avg_q;
  assign cal_o = cal_q;

  assign mag = job_sums_i[0][SumBits-1] ? SumBits'(-job_sums_i[0])
                                        : job_sums_i[0];
  assign trial = {rem_q[RatioBits-1:0], quo_q[SumBits-1]};
  assign sq = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign sat_avg = (sq > 39'sd2147483647) ? 32'sh7fffffff :
                   (sq < -39'sd2147483648) ? 32'sh80000000 : 32'(sq);
  assign prod = AccBits'(cal_coef(ch_q, col_q)) * AccBits'($signed(avg_q[col_q]));
  assign shifted = (acc_q + prod) >>> FracBits;

  // The job stays at the queue head until the back part is done with it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ch_q <= '0;
      col_q <= '0;
      bit_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
      neg_q <= 1'b0;
      acc_q <= '0;
      avg_q <= '0;
      cal_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: if (job_valid_i) begin
          state_q <= StDiv;
          ch_q <= '0;
          bit_q <= '0;
          rem_q <= '0;
          quo_q <= mag;
          neg_q <= job_sums_i[0][SumBits-1];
        end
        StDiv: begin
          if (trial >= {1'b0, ratio_i}) begin
            rem_q <= trial - {1'b0, ratio_i};
            quo_q <= {quo_q[SumBits-2:0], 1'b1};
          end else begin
            rem_q <= trial;
            quo_q <= {quo_q[SumBits-2:0], 1'b0};
          end
          bit_q <= bit_q + 1'b1;
          if (bit_q == CntBits'(SumBits)) begin
            avg_q[ch_q] <= sat_avg;
            bit_q <= '0;
            rem_q <= '0;
            if (ch_q == 3'(Chans-1)) begin
              state_q <= StMac;
              ch_q <= '0;
              col_q <= '0;
              acc_q <= '0;
            end else begin
              ch_q <= ch_q + 1'b1;
            end
          end
        end
        StMac: begin
          acc_q <= acc_q + prod;
          col_q <= col_q + 1'b1;
          if (col_q == 3'(Chans-1)) begin
            cal_q[ch_q] <= (shifted > 56'sd2147483647) ? 32'sh7fffffff :
                           (shifted < -56'sd2147483648) ? 32'sh80000000 : 32'(shifted);
            col_q <= '0;
            acc_q <= '0;
            if (ch_q == 3'(Chans-1)) state_q <= StOut;
            else ch_q <= ch_q + 1'b1;
          end
        end
        StOut: if (res_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
      // Load the next channel's magnitude right after a channel finishes.
      if (state_q == StDiv && bit_q == CntBits'(SumBits) && ch_q != 3'(Chans-1)) begin
        quo_q <= job_sums_i[ch_q+1][SumBits-1] ? SumBits'(-job_sums_i[ch_q+1])
                                               : job_sums_i[ch_q+1];
        neg_q <= job_sums_i[ch_q+1][SumBits-1];
      end
    end
  end
endmodule
